// ===== hdl/aabbpt_pkg.sv =====
// Shared types and constants for the projective box transform.
// No dependencies; every module of the block imports this package.
package aabbpt_pkg;

   localparam int FIELD_W     = 32;
   localparam int NUM_CORNERS = 8;
   localparam int NUM_AXES    = 3;
   localparam int MAT_ROWS    = 4;
   localparam int MAT_COLS    = 4;
   localparam int MAT_DEPTH   = MAT_ROWS * MAT_COLS;
   localparam int PROD_W      = 2 * FIELD_W;
   localparam int QUOT_W      = 32;
   localparam int FRAC_BITS   = 16;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_BOX  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [1:0]         row_index;
      logic signed [31:0] row_c0;
      logic signed [31:0] row_c1;
      logic signed [31:0] row_c2;
      logic signed [31:0] row_c3;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_min_x;
      logic signed [31:0] out_min_y;
      logic signed [31:0] out_min_z;
      logic signed [31:0] out_max_x;
      logic signed [31:0] out_max_y;
      logic signed [31:0] out_max_z;
      logic               fault;
   } rsp_type;

   // Position of a corner within its box
   typedef struct packed {
      logic first;
      logic last;
   } tag_type;

endpackage

// ===== hdl/aabbpt_seq.sv =====
// Matrix registers and corner sequencer: issues one box corner per cycle.
// Corners hold while adv is low. Depends on aabbpt_pkg.
module aabbpt_seq import aabbpt_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_type                           req,
   output logic                              crn_valid,
   output tag_type                           crn_tag,
   output logic [NUM_AXES-1:0][FIELD_W-1:0]  crn_v,
   output logic [MAT_DEPTH-1:0][FIELD_W-1:0] mat
);

   localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
   localparam int SH = FIELD_W - CW;

   logic [MAT_DEPTH-1:0][FIELD_W-1:0] mat_ff;
   logic [NUM_AXES-1:0][FIELD_W-1:0]  lo_ff, lo_in;
   logic [NUM_AXES-1:0][FIELD_W-1:0]  hi_ff, hi_in;
   logic [2:0]                        cnt_ff;
   logic                              busy_ff;
   logic                              last;
   logic                              accept;
   logic [FIELD_W-1:0]                row [MAT_COLS];

   assign last      = (cnt_ff == 3'(NUM_CORNERS - 1));
   assign req_ready = adv && (!busy_ff || last);
   assign accept    = req_valid && req_ready;

   // Reduce box inputs to the coordinate width
   always_comb begin
      lo_in[0] = FIELD_W'($signed(req.box_min_x <<< SH) >>> SH);
      lo_in[1] = FIELD_W'($signed(req.box_min_y <<< SH) >>> SH);
      lo_in[2] = FIELD_W'($signed(req.box_min_z <<< SH) >>> SH);
      hi_in[0] = FIELD_W'($signed(req.box_max_x <<< SH) >>> SH);
      hi_in[1] = FIELD_W'($signed(req.box_max_y <<< SH) >>> SH);
      hi_in[2] = FIELD_W'($signed(req.box_max_z <<< SH) >>> SH);
      row[0]   = req.row_c0;
      row[1]   = req.row_c1;
      row[2]   = req.row_c2;
      row[3]   = req.row_c3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (adv) begin
         if (accept && req.mode == MODE_BOX) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.mode == MODE_BOX) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (accept && req.mode == MODE_LOAD) begin
         for (int c = 0; c < MAT_COLS; c++) begin
            mat_ff[{req.row_index, 2'(c)}] <= row[c];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         crn_v[a] = cnt_ff[a] ? hi_ff[a] : lo_ff[a];
      end
   end

   assign crn_valid     = busy_ff;
   assign crn_tag.first = (cnt_ff == '0);
   assign crn_tag.last  = last;
   assign mat           = mat_ff;

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && adv && !last |=> busy_ff && cnt_ff == $past(cnt_ff) + 3'd1)
      else $error("corner counter skipped or repeated a corner");

   a_no_accept_mid_box: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !last |-> !req_ready)
      else $error("transaction taken while corners remain");

endmodule

// ===== hdl/aabbpt_xform.sv =====
// Matrix multiply of one corner: products, two adder stages, sign/magnitude.
// Depends on aabbpt_pkg.
module aabbpt_xform import aabbpt_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  tag_type                           in_tag,
   input  logic [NUM_AXES-1:0][FIELD_W-1:0]  in_v,
   input  logic [MAT_DEPTH-1:0][FIELD_W-1:0] mat,
   output logic                              out_valid,
   output tag_type                           out_tag,
   output logic [NUM_AXES-1:0][PROD_W-1:0]   out_num,
   output logic [NUM_AXES-1:0]               out_neg,
   output logic [PROD_W-1:0]                 out_den,
   output logic                              out_wzero
);

   logic [3:0] vld_ff;
   tag_type    tag_ff [4];

   logic signed [PROD_W-1:0] prod_ff [MAT_ROWS][NUM_AXES];
   logic signed [PROD_W-1:0] prod_in [MAT_ROWS][NUM_AXES];
   logic signed [PROD_W-1:0] wt_ff   [MAT_ROWS];
   logic signed [PROD_W-1:0] wt_in   [MAT_ROWS];
   logic [PROD_W:0]          s01_ff  [MAT_ROWS];
   logic [PROD_W:0]          s23_ff  [MAT_ROWS];
   logic [PROD_W+1:0]        sum_ff  [MAT_ROWS];
   logic [NUM_AXES-1:0][PROD_W-1:0] num_ff;
   logic [NUM_AXES-1:0]      neg_ff;
   logic [PROD_W-1:0]        den_ff;
   logic                     wz_ff;

   always_comb begin
      for (int r = 0; r < MAT_ROWS; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            prod_in[r][c] = $signed(mat[r*MAT_COLS+c]) * $signed(in_v[c]);
         end
         // w is one in Q16.16: the last column only shifts
         wt_in[r] = $signed({{(FIELD_W-FRAC_BITS){mat[r*MAT_COLS+3][FIELD_W-1]}},
                             mat[r*MAT_COLS+3], FRAC_BITS'(0)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < 4; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         for (int r = 0; r < MAT_ROWS; r++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
            wt_ff[r]  <= wt_in[r];
            s01_ff[r] <= {prod_ff[r][0][PROD_W-1], prod_ff[r][0]}
                       + {prod_ff[r][1][PROD_W-1], prod_ff[r][1]};
            s23_ff[r] <= {prod_ff[r][2][PROD_W-1], prod_ff[r][2]}
                       + {wt_ff[r][PROD_W-1], wt_ff[r]};
            sum_ff[r] <= {s01_ff[r][PROD_W], s01_ff[r]} + {s23_ff[r][PROD_W], s23_ff[r]};
         end
         for (int a = 0; a < NUM_AXES; a++) begin
            num_ff[a] <= sum_ff[a][PROD_W+1] ? (~sum_ff[a][PROD_W-1:0] + PROD_W'(1))
                                             : sum_ff[a][PROD_W-1:0];
            neg_ff[a] <= sum_ff[a][PROD_W+1] ^ sum_ff[3][PROD_W+1];
         end
         den_ff <= sum_ff[3][PROD_W+1] ? (~sum_ff[3][PROD_W-1:0] + PROD_W'(1))
                                       : sum_ff[3][PROD_W-1:0];
         wz_ff  <= (sum_ff[3][PROD_W-1:0] == '0);
      end
   end

   assign out_valid = vld_ff[3];
   assign out_tag   = tag_ff[3];
   assign out_num   = num_ff;
   assign out_neg   = neg_ff;
   assign out_den   = den_ff;
   assign out_wzero = wz_ff;

endmodule

// ===== hdl/aabbpt_div.sv =====
// Pipelined restoring divider, three lanes sharing the w divisor.
// Forms (num * 2^16) / den, two quotient bits per stage. Depends on aabbpt_pkg.
module aabbpt_div import aabbpt_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  tag_type                          in_tag,
   input  logic [NUM_AXES-1:0][PROD_W-1:0]  in_num,
   input  logic [NUM_AXES-1:0]              in_neg,
   input  logic [PROD_W-1:0]                in_den,
   input  logic                             in_wzero,
   output logic                             out_valid,
   output tag_type                          out_tag,
   output logic [NUM_AXES-1:0][QUOT_W-1:0]  out_q,
   output logic [NUM_AXES-1:0]              out_ovf,
   output logic [NUM_AXES-1:0]              out_neg,
   output logic                             out_wzero
);

   localparam int STEPS = 2;
   localparam int NST   = QUOT_W / STEPS;

   logic [NST:0]             vld_ff;
   tag_type                  tag_ff [NST+1];
   logic [NST:0]             wz_ff;
   logic [PROD_W-1:0]        den_ff [NST+1];
   logic [NUM_AXES-1:0]      ovf_ff [NST+1];
   logic [NUM_AXES-1:0]      neg_ff [NST+1];
   logic [PROD_W-1:0]        rem_ff [NST+1][NUM_AXES];
   logic [QUOT_W-1:0]        lo_ff  [NST+1][NUM_AXES];
   logic [QUOT_W-1:0]        q_ff   [NST+1][NUM_AXES];
   logic [PROD_W-1:0]        rem_in [NST+1][NUM_AXES];
   logic [QUOT_W-1:0]        lo_in  [NST+1][NUM_AXES];
   logic [QUOT_W-1:0]        q_in   [NST+1][NUM_AXES];
   logic [NUM_AXES-1:0]      ovf_in;

   // Stage 0: flag a quotient of 2^32 or more as overflow; start with the top bits.
   // Later stages: two restoring steps per lane.
   always_comb begin
      logic [PROD_W:0]     r2;
      logic [PROD_W:0]     diff;
      logic [PROD_W-1:0]   r;
      logic [QUOT_W-1:0]   lo;
      logic [QUOT_W-1:0]   q;
      r2   = '0;
      diff = '0;
      r    = '0;
      lo   = '0;
      q    = '0;
      for (int l = 0; l < NUM_AXES; l++) begin
         ovf_in[l]    = {FRAC_BITS'(0), in_num[l]} >= {in_den, FRAC_BITS'(0)};
         rem_in[0][l] = PROD_W'(in_num[l][PROD_W-1:FRAC_BITS]);
         lo_in[0][l]  = {in_num[l][FRAC_BITS-1:0], FRAC_BITS'(0)};
         q_in[0][l]   = '0;
      end
      for (int s = 0; s < NST; s++) begin
         for (int l = 0; l < NUM_AXES; l++) begin
            r  = rem_ff[s][l];
            lo = lo_ff[s][l];
            q  = q_ff[s][l];
            for (int k = 0; k < STEPS; k++) begin
               r2   = {r, lo[QUOT_W-1]};
               diff = r2 - {1'b0, den_ff[s]};
               if (r2 >= {1'b0, den_ff[s]}) begin
                  r = diff[PROD_W-1:0];
                  q = {q[QUOT_W-2:0], 1'b1};
               end else begin
                  r = r2[PROD_W-1:0];
                  q = {q[QUOT_W-2:0], 1'b0};
               end
               lo = {lo[QUOT_W-2:0], 1'b0};
            end
            rem_in[s+1][l] = r;
            lo_in[s+1][l]  = lo;
            q_in[s+1][l]   = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         wz_ff[0]  <= in_wzero;
         den_ff[0] <= in_den;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= in_neg;
         for (int s = 1; s <= NST; s++) begin
            tag_ff[s] <= tag_ff[s-1];
            wz_ff[s]  <= wz_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
         for (int s = 0; s <= NST; s++) begin
            for (int l = 0; l < NUM_AXES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               lo_ff[s][l]  <= lo_in[s][l];
               q_ff[s][l]   <= q_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_AXES; l++) begin
         out_q[l] = q_ff[NST][l];
      end
   end

   assign out_valid = vld_ff[NST];
   assign out_tag   = tag_ff[NST];
   assign out_ovf   = ovf_ff[NST];
   assign out_neg   = neg_ff[NST];
   assign out_wzero = wz_ff[NST];

endmodule

// ===== hdl/aabbpt_reduce.sv =====
// Saturation of quotients and min/max reduction over a box's corners.
// Holds the result register. Depends on aabbpt_pkg.
module aabbpt_reduce import aabbpt_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  tag_type                         in_tag,
   input  logic [NUM_AXES-1:0][QUOT_W-1:0] in_q,
   input  logic [NUM_AXES-1:0]             in_ovf,
   input  logic [NUM_AXES-1:0]             in_neg,
   input  logic                            in_wzero,
   output logic                            rsp_valid,
   output rsp_type                         rsp
);

   localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
   localparam logic [QUOT_W-1:0] LIM_POS = QUOT_W'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic [QUOT_W-1:0] LIM_NEG = QUOT_W'(64'd1 << (CW - 1));

   logic                      pv_ff;
   tag_type                   ptag_ff;
   logic                      pwz_ff;
   logic signed [FIELD_W-1:0] p_ff  [NUM_AXES];
   logic signed [FIELD_W-1:0] p_in  [NUM_AXES];
   logic signed [FIELD_W-1:0] mn_ff [NUM_AXES];
   logic signed [FIELD_W-1:0] mn_in [NUM_AXES];
   logic signed [FIELD_W-1:0] mx_ff [NUM_AXES];
   logic signed [FIELD_W-1:0] mx_in [NUM_AXES];
   logic                      fault_ff, fault_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   logic [QUOT_W-1:0]         lim;
   logic [QUOT_W-1:0]         qs;

   always_comb begin
      lim = '0;
      qs  = '0;
      for (int l = 0; l < NUM_AXES; l++) begin
         lim     = in_neg[l] ? LIM_NEG : LIM_POS;
         qs      = (in_ovf[l] || in_q[l] > lim) ? lim : in_q[l];
         p_in[l] = $signed(in_neg[l] ? (~qs + QUOT_W'(1)) : qs);
      end
   end

   // First corner opens the box; a later zero-w corner only raises fault
   always_comb begin
      fault_in = ptag_ff.first ? pwz_ff : (fault_ff || pwz_ff);
      for (int l = 0; l < NUM_AXES; l++) begin
         if (ptag_ff.first) begin
            mn_in[l] = p_ff[l];
            mx_in[l] = p_ff[l];
         end else if (!pwz_ff) begin
            mn_in[l] = (p_ff[l] < mn_ff[l]) ? p_ff[l] : mn_ff[l];
            mx_in[l] = (p_ff[l] > mx_ff[l]) ? p_ff[l] : mx_ff[l];
         end else begin
            mn_in[l] = mn_ff[l];
            mx_in[l] = mx_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pv_ff        <= in_valid;
         rsp_valid_ff <= pv_ff && ptag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ptag_ff <= in_tag;
         pwz_ff  <= in_wzero;
         p_ff    <= p_in;
         if (pv_ff) begin
            mn_ff    <= mn_in;
            mx_ff    <= mx_in;
            fault_ff <= fault_in;
         end
         if (pv_ff && ptag_ff.last) begin
            rsp_ff.out_min_x <= fault_in ? '0 : mn_in[0];
            rsp_ff.out_min_y <= fault_in ? '0 : mn_in[1];
            rsp_ff.out_min_z <= fault_in ? '0 : mn_in[2];
            rsp_ff.out_max_x <= fault_in ? '0 : mx_in[0];
            rsp_ff.out_max_y <= fault_in ? '0 : mx_in[1];
            rsp_ff.out_max_z <= fault_in ? '0 : mx_in[2];
            rsp_ff.fault     <= fault_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/aabb_projective_transform.sv =====
// Projective transform of an axis-aligned box by a loaded 4x4 Q16.16 matrix.
// One corner per cycle while the pipeline advances; a new box or row load is
// taken while the last corner of the previous box issues.
// Whole pipeline holds while a result waits; the result register frees it.
// Reset clears valid and sequencer state; the matrix is undefined until loaded.
// Depends on aabbpt_pkg, aabbpt_seq, aabbpt_xform, aabbpt_div, aabbpt_reduce.
module aabb_projective_transform import aabbpt_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic                              adv;
   logic                              crn_valid;
   tag_type                           crn_tag;
   logic [NUM_AXES-1:0][FIELD_W-1:0]  crn_v;
   logic [MAT_DEPTH-1:0][FIELD_W-1:0] mat;
   logic                              xf_valid;
   tag_type                           xf_tag;
   logic [NUM_AXES-1:0][PROD_W-1:0]   xf_num;
   logic [NUM_AXES-1:0]               xf_neg;
   logic [PROD_W-1:0]                 xf_den;
   logic                              xf_wzero;
   logic                              dv_valid;
   tag_type                           dv_tag;
   logic [NUM_AXES-1:0][QUOT_W-1:0]   dv_q;
   logic [NUM_AXES-1:0]               dv_ovf;
   logic [NUM_AXES-1:0]               dv_neg;
   logic                              dv_wzero;

   // Advance every stage together whenever the result register can take data
   assign adv = !rsp_valid || rsp_ready;

   aabbpt_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
      .clock, .reset, .adv, .req_valid, .req_ready, .req,
      .crn_valid, .crn_tag, .crn_v, .mat
   );

   aabbpt_xform u_xform (
      .clock, .reset, .adv,
      .in_valid(crn_valid), .in_tag(crn_tag), .in_v(crn_v), .mat,
      .out_valid(xf_valid), .out_tag(xf_tag), .out_num(xf_num),
      .out_neg(xf_neg), .out_den(xf_den), .out_wzero(xf_wzero)
   );

   aabbpt_div u_div (
      .clock, .reset, .adv,
      .in_valid(xf_valid), .in_tag(xf_tag), .in_num(xf_num), .in_neg(xf_neg),
      .in_den(xf_den), .in_wzero(xf_wzero),
      .out_valid(dv_valid), .out_tag(dv_tag), .out_q(dv_q), .out_ovf(dv_ovf),
      .out_neg(dv_neg), .out_wzero(dv_wzero)
   );

   aabbpt_reduce #(.COORD_WIDTH(COORD_WIDTH)) u_reduce (
      .clock, .reset, .adv,
      .in_valid(dv_valid), .in_tag(dv_tag), .in_q(dv_q), .in_ovf(dv_ovf),
      .in_neg(dv_neg), .in_wzero(dv_wzero),
      .rsp_valid, .rsp
   );

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("transaction taken while the pipeline is held");

   a_fault_zero_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.fault |-> rsp.out_min_x == '0 && rsp.out_min_y == '0
         && rsp.out_min_z == '0 && rsp.out_max_x == '0 && rsp.out_max_y == '0
         && rsp.out_max_z == '0)
      else $error("faulted result carries a non-zero box");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.fault |-> rsp.out_min_x <= rsp.out_max_x
         && rsp.out_min_y <= rsp.out_max_y && rsp.out_min_z <= rsp.out_max_z)
      else $error("reduced box has min above max");

endmodule
